// ===== hw/rtl/pllq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pllq_pkg;

	localparam int unsigned WordWidth = 48;
	localparam int unsigned SlopeWidth = 32;
	localparam int unsigned CfgIndexWidth = 3;

	localparam logic [7:0] CODE_NODATA = 8'd255;
	localparam logic [7:0] CODE_MAX = 8'd254;
	localparam logic [7:0] CODE_ZERO = 8'd0;

	localparam logic [26:0] LOG10_2_Q28 = 27'd80807124;

	localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

	localparam logic signed [47:0] INTERCEPT_RST = 48'sd0;
	localparam logic [31:0] INV_SLOPE_RST = 32'd65536;
	localparam logic signed [47:0] CLAMP_LOW_RST = 48'sd0;
	localparam logic signed [47:0] CLAMP_HIGH_RST = 48'sd16646144;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_LOG_MODE = 3'd0,
		REG_INTERCEPT = 3'd1,
		REG_INV_SLOPE = 3'd2,
		REG_CLAMP_LOW = 3'd3,
		REG_CLAMP_HIGH = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [47:0] sample;
		logic frame_start;
	} sample_word_t;

	typedef struct packed {
		logic [7:0] pixel_code;
		logic signed [47:0] running_min;
		logic signed [47:0] running_max;
	} pixel_word_t;

	typedef struct packed {
		logic log_mode;
		logic signed [47:0] intercept;
		logic [31:0] inverse_slope;
		logic signed [47:0] clamp_low;
		logic signed [47:0] clamp_high;
	} cfg_t;

	typedef struct packed {
		logic signed [47:0] sample;
		logic nodata;
		logic signed [47:0] run_min;
		logic signed [47:0] run_max;
	} qent_t;

	// log2(1 + i / 2^bits), 30 fraction bits, by repeated squaring
	function automatic logic [29:0] log2_frac(input int unsigned i, input int unsigned bits);
		logic [63:0] x;
		logic [29:0] r;
		x = (64'd1 << 30) + (64'(i) << (30 - bits));
		r = '0;
		for (int k = 29; k >= 0; k--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r[k] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pllq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pllq_queue
	import pllq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire qent_t push_word,
	output logic pop_valid,
	input wire logic pop_ready,
	output qent_t pop_word
);

	qent_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_word = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pllq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pllq_front
	import pllq_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire sample_word_t sample_word,
	output logic push_valid,
	input wire logic push_ready,
	output qent_t push_word
);

	localparam logic [63:0] MarkRaw = 64'd9000000 << FRAC_BITS;
	localparam bit MarkSat = (MarkRaw > 64'(S48_MAX));
	localparam logic signed [47:0] MarkPos = MarkSat ? S48_MAX : MarkRaw[47:0];
	localparam logic signed [47:0] MarkNeg = MarkSat ? S48_MIN : -MarkRaw[47:0];

	logic signed [47:0] min_q;
	logic signed [47:0] max_q;
	logic signed [47:0] s;
	logic signed [47:0] base_min;
	logic signed [47:0] base_max;
	logic signed [47:0] new_min;
	logic signed [47:0] new_max;
	logic accept;

	assign sample_ready = push_ready;
	assign push_valid = sample_valid;
	assign accept = sample_valid && sample_ready;

	always_comb begin
		s = $signed(sample_word.sample);
		base_min = sample_word.frame_start ? MarkPos : min_q;
		base_max = sample_word.frame_start ? MarkNeg : max_q;
		new_max = (s > base_max) ? s : base_max;
		new_min = ((s < base_min) && (s > MarkNeg)) ? s : base_min;
		push_word.sample = s;
		push_word.nodata = (s < MarkNeg);
		push_word.run_min = new_min;
		push_word.run_max = new_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MarkPos;
			max_q <= MarkNeg;
		end else if (accept) begin
			min_q <= new_min;
			max_q <= new_max;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pllq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pllq_back
	import pllq_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire qent_t pop_word,
	output logic pixel_valid,
	input wire logic pixel_ready,
	output pixel_word_t pixel_word
);

	localparam int TabSize = 1 << LOG_TABLE_BITS;
	localparam int Shift = FRAC_BITS + 16;
	localparam int LogShift = 58 - FRAC_BITS;
	localparam logic [79:0] SatLevel = 80'd255 << Shift;
	localparam logic [79:0] Half = 80'd1 << (Shift - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_NORM,
		ST_TAB,
		ST_L2,
		ST_LOG,
		ST_SUB,
		ST_SUM,
		ST_RND,
		ST_DONE
	} state_t;

	state_t state_q;
	logic out_valid_q;
	pixel_word_t out_word_q;

	qent_t item_q;
	logic signed [47:0] v_q;
	logic [46:0] norm_q;
	logic [5:0] pos_q;
	logic [29:0] rom_q;
	logic neg_q;
	logic [50:0] lpl_q;
	logic [39:0] lph_q;
	logic zero_q;
	logic [55:0] pl_q;
	logic [55:0] ph_q;
	logic [79:0] prod_q;
	logic [7:0] code_q;

	logic [29:0] rom [TabSize];

	logic signed [47:0] lo_sel;
	logic signed [47:0] clamped;
	logic [46:0] u;
	logic coarse;
	logic fine;
	logic signed [6:0] expo;
	logic [36:0] l2;
	logic [36:0] mag;
	logic [63:0] log_sum;
	logic [63:0] log_res;
	logic signed [48:0] d;
	logic [79:0] rounded;
	logic [7:0] code_next;
	logic out_free;

	for (genvar g = 0; g < TabSize; g++) begin : g_rom
		assign rom[g] = log2_frac(g, LOG_TABLE_BITS);
	end

	assign pop_ready = (state_q == ST_IDLE);
	assign pixel_valid = out_valid_q;
	assign pixel_word = out_word_q;
	assign out_free = !out_valid_q || pixel_ready;

	always_comb begin
		lo_sel = ($signed(item_q.sample) > $signed(cfg.clamp_low)) ? item_q.sample : cfg.clamp_low;
		clamped = (lo_sel > $signed(cfg.clamp_high)) ? cfg.clamp_high : lo_sel;
		u = (clamped <= 48'sd0) ? 47'd1 : clamped[46:0];

		coarse = (norm_q[46:39] == 8'd0) && (pos_q >= 6'd8);
		fine = !norm_q[46] && (pos_q != 6'd0);

		expo = $signed({1'b0, pos_q}) - 7'(FRAC_BITS);
		l2 = {expo, 30'd0} + 37'(rom_q);
		mag = l2[36] ? (37'd0 - l2) : l2;

		log_sum = 64'(lpl_q) + (64'(lph_q) << 24);
		log_res = log_sum >> LogShift;

		d = {v_q[47], v_q} - {cfg.intercept[47], cfg.intercept};

		rounded = (prod_q + Half) >> Shift;
		if (zero_q) begin
			code_next = CODE_ZERO;
		end else if (prod_q >= SatLevel) begin
			code_next = CODE_MAX;
		end else if (rounded[7:0] > CODE_MAX) begin
			code_next = CODE_MAX;
		end else begin
			code_next = rounded[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pixel_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (item_q.nodata) begin
						state_q <= ST_DONE;
					end else if (cfg.log_mode) begin
						state_q <= ST_NORM;
					end else begin
						state_q <= ST_SUB;
					end
				end
				ST_NORM: begin
					if (!coarse && !fine) begin
						state_q <= ST_TAB;
					end
				end
				ST_TAB: state_q <= ST_L2;
				ST_L2: state_q <= ST_LOG;
				ST_LOG: state_q <= ST_SUB;
				ST_SUB: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_RND;
				ST_RND: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_word_q.pixel_code <= code_q;
						out_word_q.running_min <= item_q.run_min;
						out_word_q.running_max <= item_q.run_max;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					item_q <= pop_word;
				end
			end
			ST_CLAMP: begin
				v_q <= clamped;
				norm_q <= u;
				pos_q <= 6'd46;
				code_q <= CODE_NODATA;
			end
			ST_NORM: begin
				if (coarse) begin
					norm_q <= norm_q << 8;
					pos_q <= pos_q - 6'd8;
				end else if (fine) begin
					norm_q <= norm_q << 1;
					pos_q <= pos_q - 6'd1;
				end
			end
			ST_TAB: begin
				rom_q <= rom[norm_q[45 -: LOG_TABLE_BITS]];
			end
			ST_L2: begin
				neg_q <= l2[36];
				lpl_q <= 51'(mag[23:0]) * 51'(LOG10_2_Q28);
				lph_q <= 40'(mag[36:24]) * 40'(LOG10_2_Q28);
			end
			ST_LOG: begin
				v_q <= neg_q ? (48'sd0 - $signed(log_res[47:0])) : $signed(log_res[47:0]);
			end
			ST_SUB: begin
				zero_q <= d[48] || (d == 49'sd0) || (cfg.inverse_slope == 32'd0);
				pl_q <= 56'(d[23:0]) * 56'(cfg.inverse_slope);
				ph_q <= 56'(d[47:24]) * 56'(cfg.inverse_slope);
			end
			ST_SUM: begin
				prod_q <= 80'(pl_q) + (80'(ph_q) << 24);
			end
			ST_RND: begin
				code_q <= code_next;
			end
			ST_DONE: begin
				item_q <= item_q;
			end
			default: begin
				item_q <= item_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_linear_log_quantizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// sample    sample_valid/sample_ready  sample_word (sample, frame_start)
// pixel     pixel_valid/pixel_ready    pixel_word (pixel_code, running_min, running_max)
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Linear mode: clamp, subtract, sum, round, done. In either mode no-data goes clamp to done.
// Log mode: normalize loop (8 bits or 1 bit a step), table, log2, log, then subtract onward.
// Trackers update at accept; a 2-entry queue lets the front take words while the back works.
// Reset clears trackers to the no-data marks and registers to their defaults.
// cfg_ready is always high.

module pixel_linear_log_quantizer_top
	import pllq_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire sample_word_t sample_word,
	output logic pixel_valid,
	input wire logic pixel_ready,
	output pixel_word_t pixel_word,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CfgIndexWidth-1:0] cfg_index,
	input wire logic [WordWidth-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	qent_t push_word;
	logic pop_valid;
	logic pop_ready;
	qent_t pop_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.log_mode <= 1'b0;
			cfg_q.intercept <= INTERCEPT_RST;
			cfg_q.inverse_slope <= INV_SLOPE_RST;
			cfg_q.clamp_low <= CLAMP_LOW_RST;
			cfg_q.clamp_high <= CLAMP_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOG_MODE: cfg_q.log_mode <= cfg_data[0];
				REG_INTERCEPT: cfg_q.intercept <= cfg_data;
				REG_INV_SLOPE: cfg_q.inverse_slope <= cfg_data[SlopeWidth-1:0];
				REG_CLAMP_LOW: cfg_q.clamp_low <= cfg_data;
				REG_CLAMP_HIGH: cfg_q.clamp_high <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pllq_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word(sample_word),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word(push_word)
	);

	pllq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word(push_word),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_word(pop_word)
	);

	pllq_back #(
		.FRAC_BITS(FRAC_BITS),
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_word(pop_word),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_word(pixel_word)
	);

endmodule

`default_nettype wire
